/* src/srp_pkg.sv */
// Shared types and constants for the stepper ramp profile generator.
// No dependencies; imported by the interfaces, the divider and the top level.
package srp_pkg;

  localparam int unsigned DelayW = 16;
  localparam int unsigned NumW   = DelayW + 1;   // 2 * delay
  localparam int unsigned DenW   = DelayW + 2;   // 4 * n + 1
  localparam int unsigned CntW   = $clog2(NumW + 1);

  localparam logic [DelayW-1:0] RELOAD_BASE = 16'hFFFF;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } srp_state_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } srp_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quo;
  } srp_div_rsp_t;

endpackage

/* src/srp_if.sv */
// Valid/ready channel interfaces for the ramp generator's input and result items.
// Depends on srp_pkg for the delay width.
interface srp_in_if import srp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic              direction;
  logic [DelayW-1:0] step_count;
  logic [DelayW-1:0] initial_delay;

  modport source (output valid, func, direction, step_count, initial_delay, input ready);
  modport sink   (input valid, func, direction, step_count, initial_delay, output ready);
endinterface

interface srp_out_if import srp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              step_pulse;
  logic [DelayW-1:0] reload_value;
  logic              busy_res;
  logic              dir_level;
  logic [DelayW-1:0] delay_now;

  modport source (output valid, step_pulse, reload_value, busy_res, dir_level, delay_now,
                  input ready);
  modport sink   (input valid, step_pulse, reload_value, busy_res, dir_level, delay_now,
                  output ready);
endinterface

/* src/srp_div.sv */
// Restoring radix-2 divider: one quotient bit per cycle, NumW quotient bits per divide.
// Depends on srp_pkg for widths and the request/response structs.
module srp_div import srp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  srp_div_req_t req,
  output srp_div_rsp_t rsp
);

  logic [DenW-1:0] rem_r, rem_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            fits;

  always_comb begin
    trial    = {rem_r, quo_r[NumW-1]};
    diff     = trial - {1'b0, den_r};
    fits     = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start && !run_r) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = CntW'(NumW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_nxt = fits ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_nxt = {quo_r[NumW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = run_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r))
    else $error("divider done without a running divide");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> cnt_r == '0)
    else $error("divider count nonzero while idle");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && !done_nxt |=> run_r)
    else $error("divider stopped early");

endmodule

/* src/stepper_ramp_profile.sv */
// Stepper ramp profile generator: start and tick items in, one result item per input item.
// Start items, done ticks and ticks outside both ramp phases have their result registered in the
// cycle after acceptance; ticks in a ramp phase give their result once the shared divider finishes.
// Throughput: one item at a time; the next item is taken once the result register is free.
// Reset (rst_n low, synchronous) clears the move state but speed_up_r and reload_r, and the result valid.
module stepper_ramp_profile import srp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  srp_in_if.sink    in_if,
  srp_out_if.source out_if
);

  srp_state_t        state_r, state_nxt;
  logic [DelayW-1:0] steps_total_r, steps_total_nxt;
  logic [DelayW-1:0] accel_limit_r, accel_limit_nxt;
  logic [DelayW-1:0] step_index_r, step_index_nxt;
  logic [DelayW-1:0] half_delay_r, half_delay_nxt;
  logic              in_flight_r, in_flight_nxt;
  logic              dir_pin_r, dir_pin_nxt;
  logic              speed_up_r, speed_up_nxt;
  logic [DelayW-1:0] reload_r, reload_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_pulse_r, out_pulse_nxt;
  logic [DelayW-1:0] out_reload_r, out_reload_nxt;
  logic              out_busy_r, out_busy_nxt;
  logic              out_dir_r, out_dir_nxt;
  logic [DelayW-1:0] out_delay_r, out_delay_nxt;

  srp_div_req_t      div_req;
  srp_div_rsp_t      div_rsp;

  logic              accept;
  logic [DelayW-1:0] idx_inc;
  logic [DelayW:0]   idx_plus_lim;
  logic [DelayW-1:0] remain;
  logic [DelayW-1:0] quo16;
  logic [DelayW-1:0] shrunk;

  srp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    idx_inc      = step_index_r + 1'b1;
    idx_plus_lim = {1'b0, idx_inc} + {1'b0, accel_limit_r};
    remain       = steps_total_r - idx_inc;
    quo16        = div_rsp.quo[DelayW-1:0];
    shrunk       = half_delay_r - quo16;

    state_nxt       = state_r;
    steps_total_nxt = steps_total_r;
    accel_limit_nxt = accel_limit_r;
    step_index_nxt  = step_index_r;
    half_delay_nxt  = half_delay_r;
    in_flight_nxt   = in_flight_r;
    dir_pin_nxt     = dir_pin_r;
    speed_up_nxt    = speed_up_r;
    reload_nxt      = reload_r;

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_pulse_nxt  = out_pulse_r;
    out_reload_nxt = out_reload_r;
    out_busy_nxt   = out_busy_r;
    out_dir_nxt    = out_dir_r;
    out_delay_nxt  = out_delay_r;

    div_req.start = 1'b0;
    div_req.num   = {half_delay_r, 1'b0};
    div_req.den   = {idx_inc, 2'b01};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_pulse_nxt  = 1'b0;
          out_reload_nxt = '0;
          if (in_if.func == FUNC_START) begin
            in_flight_nxt   = 1'b1;
            steps_total_nxt = in_if.step_count;
            accel_limit_nxt = in_if.step_count >> 1;
            step_index_nxt  = '0;
            half_delay_nxt  = in_if.initial_delay;
            dir_pin_nxt     = !in_if.direction;
            out_busy_nxt    = 1'b1;
            out_dir_nxt     = !in_if.direction;
            out_delay_nxt   = in_if.initial_delay;
          end else if (step_index_r < steps_total_r) begin
            step_index_nxt = idx_inc;
            reload_nxt     = RELOAD_BASE - {half_delay_r[DelayW-2:0], 1'b0};
            out_pulse_nxt  = 1'b1;
            out_reload_nxt = RELOAD_BASE - {half_delay_r[DelayW-2:0], 1'b0};
            out_busy_nxt   = in_flight_r;
            out_dir_nxt    = dir_pin_r;
            out_delay_nxt  = half_delay_r;
            if (idx_inc < accel_limit_r) begin
              div_req.start = 1'b1;
              speed_up_nxt  = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_DIV;
            end else if (idx_plus_lim > {1'b0, steps_total_r}) begin
              div_req.start = 1'b1;
              div_req.den   = {remain, 2'b01};
              speed_up_nxt  = 1'b0;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_DIV;
            end
          end else begin
            in_flight_nxt = 1'b0;
            out_busy_nxt  = 1'b0;
            out_dir_nxt   = dir_pin_r;
            out_delay_nxt = half_delay_r;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (speed_up_r) begin
            // freeze the acceleration phase once the shrink rounds to zero
            if (quo16 == '0) begin
              accel_limit_nxt = step_index_r;
            end else begin
              half_delay_nxt = shrunk;
            end
          end else begin
            half_delay_nxt = half_delay_r + quo16;
          end
          out_valid_nxt  = 1'b1;
          out_pulse_nxt  = 1'b1;
          out_reload_nxt = reload_r;
          out_busy_nxt   = in_flight_r;
          out_dir_nxt    = dir_pin_r;
          out_delay_nxt  = (speed_up_r && quo16 == '0) ? half_delay_r :
                           (speed_up_r ? shrunk : half_delay_r + quo16);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      steps_total_r <= '0;
      accel_limit_r <= '0;
      step_index_r  <= '0;
      half_delay_r  <= '0;
      in_flight_r   <= 1'b0;
      dir_pin_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      steps_total_r <= steps_total_nxt;
      accel_limit_r <= accel_limit_nxt;
      step_index_r  <= step_index_nxt;
      half_delay_r  <= half_delay_nxt;
      in_flight_r   <= in_flight_nxt;
      dir_pin_r     <= dir_pin_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    speed_up_r   <= speed_up_nxt;
    reload_r     <= reload_nxt;
    out_pulse_r  <= out_pulse_nxt;
    out_reload_r <= out_reload_nxt;
    out_busy_r   <= out_busy_nxt;
    out_dir_r    <= out_dir_nxt;
    out_delay_r  <= out_delay_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.step_pulse   = out_pulse_r;
  assign out_if.reload_value = out_reload_r;
  assign out_if.busy_res     = out_busy_r;
  assign out_if.dir_level    = out_dir_r;
  assign out_if.delay_now    = out_delay_r;

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> state_r == ST_DIV)
    else $error("divider running outside the divide state");

  a_out_empty_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !out_valid_r)
    else $error("result register occupied while a divide is pending");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_index_r <= steps_total_r)
    else $error("step index beyond step count");

  a_no_pulse_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pulse_r |-> out_reload_r == '0)
    else $error("reload value nonzero without a step pulse");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for stepper_ramp_profile: start and tick items in, one result out.
// Depends on srp_pkg and the srp_in_if / srp_out_if channel interfaces from src.
// A ramp predictor in a small scoreboard class holds the expected results in order.
module testbench;
  import srp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned ITEM_GOAL  = 1600;

  typedef struct packed {
    logic              func;
    logic              direction;
    logic [DelayW-1:0] step_count;
    logic [DelayW-1:0] initial_delay;
  } ramp_cmd_t;

  typedef struct packed {
    logic              step_pulse;
    logic [DelayW-1:0] reload_value;
    logic              busy_res;
    logic              dir_level;
    logic [DelayW-1:0] delay_now;
  } ramp_result_t;

  class ramp_scoreboard;
    bit [DelayW-1:0] steps_total;
    bit [DelayW-1:0] accel_limit;
    bit [DelayW-1:0] step_index;
    bit [DelayW-1:0] half_delay;
    bit              moving;
    bit              dir_left;
    ramp_result_t    expected_results[$];
    int unsigned     failures;

    function automatic bit [DelayW-1:0] next_delay(bit [DelayW-1:0] d, bit [DelayW-1:0] n,
                                                   bit shrink);
      bit [DenW-1:0] num;
      bit [DenW-1:0] den;
      bit [DenW-1:0] quo;
      num = {1'b0, d, 1'b0};
      den = {n, 2'b01};
      quo = num / den;
      return shrink ? d - quo[DelayW-1:0] : d + quo[DelayW-1:0];
    endfunction

    function void note_item(ramp_cmd_t c);
      ramp_result_t    r;
      bit [DelayW-1:0] nd;
      r = '0;
      if (c.func == FUNC_START) begin
        moving      = 1'b1;
        steps_total = c.step_count;
        accel_limit = c.step_count >> 1;
        step_index  = '0;
        half_delay  = c.initial_delay;
        dir_left    = (c.direction == 1'b0);
      end else if (step_index < steps_total) begin
        r.step_pulse   = 1'b1;
        r.reload_value = RELOAD_BASE - {half_delay[DelayW-2:0], 1'b0};
        step_index     = step_index + 1'b1;
        if (step_index < accel_limit) begin
          nd = next_delay(half_delay, step_index, 1'b1);
          // freeze the ramp-up once the shrink rounds to zero
          if (nd == half_delay) accel_limit = step_index;
          else half_delay = nd;
        end else if ({1'b0, step_index} + {1'b0, accel_limit} > {1'b0, steps_total}) begin
          half_delay = next_delay(half_delay, steps_total - step_index, 1'b0);
        end
      end else begin
        moving = 1'b0;
      end
      r.busy_res  = moving;
      r.dir_level = dir_left;
      r.delay_now = half_delay;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [DelayW-1:0] exp_v, logic [DelayW-1:0] act_v);
      if (exp_v !== act_v) begin
        failures++;
        $display("%0t ERROR %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_result(ramp_result_t act);
      ramp_result_t e;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t ERROR unexpected result expected none actual %0h", $realtime, act);
        return;
      end
      e = expected_results.pop_front();
      compare_field("step_pulse", e.step_pulse, act.step_pulse);
      compare_field("reload_value", e.reload_value, act.reload_value);
      compare_field("busy_res", e.busy_res, act.busy_res);
      compare_field("dir_level", e.dir_level, act.dir_level);
      compare_field("delay_now", e.delay_now, act.delay_now);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  srp_in_if  in_ch ();
  srp_out_if out_ch ();

  stepper_ramp_profile dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ramp_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    burst_left;
  int unsigned    idle_cycles = 0;

  // observe both channels at the edge where each item moves
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.step_pulse, out_ch.reload_value, out_ch.busy_res,
                         out_ch.dir_level, out_ch.delay_now});
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item({in_ch.func, in_ch.direction, in_ch.step_count, in_ch.initial_delay});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls: always ready, coin flip, periodic, and long holds in turn
  initial begin
    int unsigned phase_cnt;
    int unsigned hold_cnt;
    phase_cnt = 0;
    hold_cnt  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase_cnt++;
      if (hold_cnt != 0) begin
        out_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        case ((phase_cnt >> 9) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (phase_cnt % 8 == 0);
          default: begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) hold_cnt = $urandom_range(5, 60);
          end
        endcase
      end
    end
  end

  // hold valid across a burst; drop it for a gap between bursts
  task automatic send_item(logic func, logic direction, logic [DelayW-1:0] step_count,
                           logic [DelayW-1:0] initial_delay);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= func;
    in_ch.direction     <= direction;
    in_ch.step_count    <= step_count;
    in_ch.initial_delay <= initial_delay;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  task automatic send_start(logic direction, logic [DelayW-1:0] count,
                            logic [DelayW-1:0] delay);
    send_item(FUNC_START, direction, count, delay);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(FUNC_TICK, 1'($urandom_range(0, 1)), DelayW'($urandom),
                         DelayW'($urandom));
  endtask

  task automatic run_moves();
    int unsigned      kind;
    logic [DelayW-1:0] count;
    logic [DelayW-1:0] delay;
    while (items_sent < ITEM_GOAL) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
        0: delay = DelayW'($urandom);
        1: delay = DelayW'($urandom_range(0, 15));
        default: delay = DelayW'($urandom_range(16'hF000, 16'hFFFF));
      endcase
      if (kind == 0) begin
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), DelayW'($urandom),
                  DelayW'($urandom));
      end else if (kind == 1) begin
        // abandon a move part way with a fresh start
        send_start(1'($urandom_range(0, 1)), DelayW'($urandom), delay);
        send_ticks($urandom_range(0, 10));
      end else begin
        count = DelayW'(($urandom_range(0, 7) == 0) ? $urandom_range(41, 300)
                                                    : $urandom_range(0, 40));
        send_start(1'($urandom_range(0, 1)), count, delay);
        send_ticks(count + $urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    sb          = new();
    items_sent  = 0;
    burst_left  = 5;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_TICK;
    in_ch.direction     <= 1'b0;
    in_ch.step_count    <= '0;
    in_ch.initial_delay <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick before any move, then an empty move
    send_ticks(1);
    send_start(1'b0, 16'd0, 16'hFFFF);
    send_ticks(1);
    // last step of the ramp-down with the widest delay wraps the quotient
    send_start(1'b1, 16'd2, 16'hFFFF);
    send_ticks(3);
    // tiny delay: the shrink rounds to zero and freezes the ramp-up
    send_start(1'b0, 16'd6, 16'd3);
    send_ticks(7);
    send_start(1'b1, 16'hFFFF, 16'd0);
    send_ticks(3);
    send_start(1'b0, 16'h8000, 16'h8000);
    send_ticks(2);

    run_moves();
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/srp_pkg.sv
src/srp_if.sv
src/srp_div.sv
src/stepper_ramp_profile.sv
sim/testbench.sv
